[src/clex_pkg.sv]
// Shared types and constants for the C-like token lexer.
package clex_pkg;

   localparam int unsigned KW_COUNT = 33;

   localparam logic [6:0] K_OP_BASE   = 7'd33;
   localparam logic [6:0] K_PUN_BASE  = 7'd73;
   localparam logic [6:0] K_IDENT     = 7'd79;
   localparam logic [6:0] K_NUM       = 7'd80;
   localparam logic [6:0] K_STR       = 7'd81;
   localparam logic [6:0] K_DIRECTIVE = 7'd82;
   localparam logic [6:0] K_LINE_CMT  = 7'd83;
   localparam logic [6:0] K_BLOCK_CMT = 7'd84;
   localparam logic [6:0] K_END       = 7'd85;
   localparam logic [6:0] K_ERROR     = 7'd86;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_EOI  = 1'b1;

   typedef enum logic [3:0] {
      M_IDLE,
      M_DIRECTIVE,
      M_SLASH,
      M_LINE,
      M_BLOCK,
      M_BLOCK_STAR,
      M_IDENT,
      M_NUMBER,
      M_STRING,
      M_OPER
   } lex_mode_type;

   typedef struct packed {
      logic       op;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic [6:0]  kind;
      logic [15:0] start_line;
      logic [11:0] start_col;
      logic [11:0] length;
      logic        last;
   } rsp_type;

   // Keyword spellings, right aligned in 64 bits, with their lengths.
   function automatic logic [63:0] kw_word(input logic [5:0] i);
      logic [63:0] w;
      begin
         case (i)
            6'd0:  w = 64'("if");
            6'd1:  w = 64'("do");
            6'd2:  w = 64'("int");
            6'd3:  w = 64'("for");
            6'd4:  w = 64'("auto");
            6'd5:  w = 64'("case");
            6'd6:  w = 64'("char");
            6'd7:  w = 64'("else");
            6'd8:  w = 64'("enum");
            6'd9:  w = 64'("goto");
            6'd10: w = 64'("long");
            6'd11: w = 64'("void");
            6'd12: w = 64'("break");
            6'd13: w = 64'("const");
            6'd14: w = 64'("float");
            6'd15: w = 64'("short");
            6'd16: w = 64'("union");
            6'd17: w = 64'("while");
            6'd18: w = 64'("double");
            6'd19: w = 64'("extern");
            6'd20: w = 64'("return");
            6'd21: w = 64'("signed");
            6'd22: w = 64'("sizeof");
            6'd23: w = 64'("static");
            6'd24: w = 64'("struct");
            6'd25: w = 64'("switch");
            6'd26: w = 64'("default");
            6'd27: w = 64'("typedef");
            6'd28: w = 64'("continue");
            6'd29: w = 64'("register");
            6'd30: w = 64'("restrict");
            6'd31: w = 64'("unsigned");
            6'd32: w = 64'("volatile");
            default: w = 64'd0;
         endcase
         return w;
      end
   endfunction

   function automatic logic [3:0] kw_len(input logic [5:0] i);
      logic [3:0] l;
      begin
         if (i < 6'd2) l = 4'd2;
         else if (i < 6'd4) l = 4'd3;
         else if (i < 6'd12) l = 4'd4;
         else if (i < 6'd18) l = 4'd5;
         else if (i < 6'd26) l = 4'd6;
         else if (i < 6'd28) l = 4'd7;
         else l = 4'd8;
         return l;
      end
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C
         || c == 8'h0D;
   endfunction

   function automatic logic is_dec_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_ident_start(input logic [7:0] c);
      return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_oper(input logic [7:0] c);
      logic r;
      begin
         case (c)
            "+", "-", "*", "/", "%", "=", ".", "&", "|", "^", "!", "~", "(", "[",
            "<", ">", "?", ":": r = 1'b1;
            default: r = 1'b0;
         endcase
         return r;
      end
   endfunction

endpackage

[src/clex_classify.sv]
// Token kind lookup: keyword match and operator-run classification.
module clex_classify import clex_pkg::*; #(
   parameter int LEN_BITS = 12
) (
   input  logic [63:0]         word_shift,
   input  logic [23:0]         head_chars,
   input  logic [LEN_BITS-1:0] tok_len,
   output logic [6:0]          ident_kind,
   output logic [6:0]          oper_kind
);

   logic [7:0] c1, c2, c3;
   logic [6:0] ofs;

   always_comb begin
      ident_kind = K_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if (tok_len == LEN_BITS'(kw_len(6'(i))) && word_shift == kw_word(6'(i)))
            ident_kind = 7'(i);
      end
   end

   always_comb begin
      c1 = head_chars[7:0];
      c2 = (tok_len >= LEN_BITS'(2)) ? head_chars[15:8] : 8'd0;
      c3 = (tok_len >= LEN_BITS'(3)) ? head_chars[23:16] : 8'd0;
      case (c1)
         "+": ofs = (c2 == "+") ? 7'd1 : (c2 == "=") ? 7'd2 : 7'd0;
         "-": ofs = (c2 == "-") ? 7'd4 : (c2 == "=") ? 7'd5 : (c2 == ">") ? 7'd6 : 7'd3;
         "*": ofs = (c2 == "=") ? 7'd8 : 7'd7;
         "/": ofs = (c2 == "=") ? 7'd10 : 7'd9;
         "%": ofs = (c2 == "=") ? 7'd12 : 7'd11;
         "=": ofs = (c2 == "=") ? 7'd14 : 7'd13;
         "&": ofs = (c2 == "=") ? 7'd16 : (c2 == "&") ? 7'd17 : 7'd15;
         "|": ofs = (c2 == "=") ? 7'd19 : (c2 == "|") ? 7'd20 : 7'd18;
         "^": ofs = (c2 == "=") ? 7'd22 : 7'd21;
         "!": ofs = (c2 == "=") ? 7'd24 : 7'd23;
         "(": ofs = 7'd25;
         ".": ofs = 7'd26;
         "[": ofs = 7'd27;
         "~": ofs = (c2 == "=") ? 7'd29 : 7'd28;
         "<": ofs = (c2 == "=") ? 7'd31 : (c2 == "<") ? ((c3 == "=") ? 7'd33 : 7'd32)
                    : 7'd30;
         ">": ofs = (c2 == "=") ? 7'd35 : (c2 == ">") ? ((c3 == "=") ? 7'd37 : 7'd36)
                    : 7'd34;
         ":": ofs = 7'd38;
         default: ofs = 7'd39;
      endcase
      oper_kind = K_OP_BASE + ofs;
   end

endmodule

[src/c_like_token_lexer_core.sv]
// Top level of the C-like token lexer: input register, lexer state, result queue.
//
// Usage:
//  - req_ carries one item per transfer: op = 0 with a source byte in ch,
//    or op = 1 to mark end of input.
//  - rsp_ carries tokens (kind, start line/column, length, last). One item
//    yields zero, one or two tokens; last marks the final token of an item.
//  - Datapath: an accepted byte is held in an input register and lexed
//    there; its tokens land in a two-deep result queue, whose head drives
//    rsp_. The byte waits in the input register while the queue lacks room.
//  - Throughput: one item per cycle while the receiver takes tokens and no
//    item yields two tokens; such an item holds the next one until the queue drains.
//  - Stall: req_stall rises while the input register holds an item and the
//    queue keeps a token that is not taken this cycle, since an item may add
//    two tokens; the input register then holds.
//  - Reset: synchronous, active high; clears the lexer state (idle, line and
//    column zero) and empties both registers. End of input also returns the
//    lexer state to its reset values.
module c_like_token_lexer_core import clex_pkg::*; #(
   parameter int LEN_BITS  = 12,
   parameter int LINE_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   // input register
   logic    in_vld_ff, in_vld_in;
   req_type in_ff, in_in;

   // lexer state
   lex_mode_type        mode_ff, mode_in;
   logic [23:0]          head_ff, head_in;
   logic [63:0]          word_ff, word_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic [LINE_BITS-1:0] tline_ff, tline_in, cline_ff, cline_in;
   logic [LEN_BITS-1:0]  tcol_ff, tcol_in, ccol_ff, ccol_in;

   // result queue, two deep
   rsp_type    q_ff [2];
   rsp_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;

   logic [6:0] ident_kind, oper_kind;
   rsp_type    r [2];
   logic [1:0] n;
   logic       fire, pop, room;

   clex_classify #(.LEN_BITS(LEN_BITS)) u_cls (
      .word_shift(word_ff),
      .head_chars(head_ff),
      .tok_len   (len_ff),
      .ident_kind(ident_kind),
      .oper_kind (oper_kind)
   );

   function automatic rsp_type mk(input logic [6:0] k, input logic [LINE_BITS-1:0] l,
                                   input logic [LEN_BITS-1:0] c,
                                   input logic [LEN_BITS-1:0] len);
      rsp_type t;
      begin
         t.kind       = k;
         t.start_line = 16'(l);
         t.start_col  = 12'(c);
         t.length     = 12'(len);
         t.last       = 1'b0;
         return t;
      end
   endfunction

   assign pop  = rsp_valid && !rsp_stall;
   // worst case an item adds two tokens
   assign room = (2'(cnt_ff) - 2'(pop)) == 2'd0;
   assign fire = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_data  = q_ff[0];

   always_comb begin
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (req_valid && !req_stall) begin
         in_vld_in = 1'b1;
         in_in     = req_data;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   // Lex one item held in the input register.
   always_comb begin
      logic [7:0]          c;
      logic                idle;
      logic [LEN_BITS-1:0] grown;
      logic [6:0]          open_kind;
      c     = in_ff.ch;
      grown = (len_ff < LEN_MAX) ? len_ff + LEN_BITS'(1) : LEN_MAX;
      mode_in = mode_ff; head_in = head_ff; word_in = word_ff; len_in = len_ff;
      tline_in = tline_ff; tcol_in = tcol_ff; cline_in = cline_ff; ccol_in = ccol_ff;
      n = 2'd0;
      r[0] = mk(K_END, cline_ff, ccol_ff, LEN_BITS'(1));
      r[1] = r[0];
      idle = 1'b0;
      case (mode_ff)
         M_DIRECTIVE:              open_kind = K_DIRECTIVE;
         M_SLASH, M_OPER:          open_kind = oper_kind;
         M_LINE:                   open_kind = K_LINE_CMT;
         M_BLOCK, M_BLOCK_STAR:    open_kind = K_BLOCK_CMT;
         M_IDENT:                  open_kind = ident_kind;
         M_NUMBER:                 open_kind = K_NUM;
         M_STRING:                 open_kind = K_STR;
         default:                  open_kind = K_ERROR;
      endcase
      if (fire) begin
         if (in_ff.op == OP_EOI) begin
            if (mode_ff != M_IDLE) begin
               r[0] = mk(open_kind, tline_ff, tcol_ff, len_ff);
               n = 2'd2;
            end else begin
               n = 2'd1;
            end
            mode_in = M_IDLE; head_in = '0; word_in = '0; len_in = '0;
            tline_in = '0; tcol_in = '0; cline_in = '0; ccol_in = '0;
         end else begin
            case (mode_ff)
               M_DIRECTIVE: begin
                  len_in = grown;
                  if (c == "\n") begin
                     r[0] = mk(K_DIRECTIVE, tline_ff, tcol_ff, grown);
                     n = 2'd1; mode_in = M_IDLE;
                  end
               end
               M_SLASH: begin
                  if (c == "/") begin
                     mode_in = M_LINE; len_in = grown;
                  end else if (c == "*") begin
                     mode_in = M_BLOCK; len_in = grown;
                  end else if (is_oper(c)) begin
                     mode_in = M_OPER; len_in = grown;
                     head_in[15:8] = c;
                  end else begin
                     r[0] = mk(open_kind, tline_ff, tcol_ff, len_ff);
                     n = 2'd1; mode_in = M_IDLE; idle = 1'b1;
                  end
               end
               M_LINE: begin
                  if (c == "\n") begin
                     r[0] = mk(K_LINE_CMT, tline_ff, tcol_ff, len_ff);
                     n = 2'd1; mode_in = M_IDLE;
                  end else begin
                     len_in = grown;
                  end
               end
               M_BLOCK: begin
                  len_in = grown;
                  if (c == "*") mode_in = M_BLOCK_STAR;
               end
               M_BLOCK_STAR: begin
                  len_in = grown;
                  if (c == "/") begin
                     r[0] = mk(K_BLOCK_CMT, tline_ff, tcol_ff, grown);
                     n = 2'd1; mode_in = M_IDLE;
                  end else if (c != "*") begin
                     mode_in = M_BLOCK;
                  end
               end
               M_IDENT: begin
                  if (is_ident_start(c) || is_dec_digit(c)) begin
                     len_in  = grown;
                     word_in = {word_ff[55:0], c};
                  end else begin
                     r[0] = mk(open_kind, tline_ff, tcol_ff, len_ff);
                     n = 2'd1; mode_in = M_IDLE; idle = 1'b1;
                  end
               end
               M_NUMBER: begin
                  if (is_dec_digit(c) || c == ".") begin
                     len_in = grown;
                  end else begin
                     r[0] = mk(K_NUM, tline_ff, tcol_ff, len_ff);
                     n = 2'd1; mode_in = M_IDLE; idle = 1'b1;
                  end
               end
               M_STRING: begin
                  len_in = grown;
                  if (c == "\"") begin
                     r[0] = mk(K_STR, tline_ff, tcol_ff, grown);
                     n = 2'd1; mode_in = M_IDLE;
                  end
               end
               M_OPER: begin
                  if (is_oper(c)) begin
                     len_in = grown;
                     if (len_ff == LEN_BITS'(1)) head_in[15:8] = c;
                     else if (len_ff == LEN_BITS'(2)) head_in[23:16] = c;
                  end else begin
                     r[0] = mk(open_kind, tline_ff, tcol_ff, len_ff);
                     n = 2'd1; mode_in = M_IDLE; idle = 1'b1;
                  end
               end
               default: idle = 1'b1;
            endcase

            // start a token or emit a one-character token
            if (idle && !is_space(c)) begin
               if (c == "#" || c == "/" || is_ident_start(c) || is_dec_digit(c)
                   || c == "\"" || is_oper(c)) begin
                  tline_in = cline_ff; tcol_in = ccol_ff; len_in = LEN_BITS'(1);
                  head_in = {16'd0, c}; word_in = {56'd0, c};
                  if (c == "#") mode_in = M_DIRECTIVE;
                  else if (c == "/") mode_in = M_SLASH;
                  else if (is_ident_start(c)) mode_in = M_IDENT;
                  else if (is_dec_digit(c)) mode_in = M_NUMBER;
                  else if (c == "\"") mode_in = M_STRING;
                  else mode_in = M_OPER;
               end else begin
                  case (c)
                     "{": r[n[0]] = mk(K_PUN_BASE, cline_ff, ccol_ff, LEN_BITS'(1));
                     "}": r[n[0]] = mk(K_PUN_BASE + 7'd1, cline_ff, ccol_ff, LEN_BITS'(1));
                     ";": r[n[0]] = mk(K_PUN_BASE + 7'd2, cline_ff, ccol_ff, LEN_BITS'(1));
                     ",": r[n[0]] = mk(K_PUN_BASE + 7'd3, cline_ff, ccol_ff, LEN_BITS'(1));
                     "]": r[n[0]] = mk(K_PUN_BASE + 7'd4, cline_ff, ccol_ff, LEN_BITS'(1));
                     ")": r[n[0]] = mk(K_PUN_BASE + 7'd5, cline_ff, ccol_ff, LEN_BITS'(1));
                     default: r[n[0]] = mk(K_ERROR, cline_ff, ccol_ff, LEN_BITS'(1));
                  endcase
                  n = n + 2'd1;
               end
            end

            // advance position
            if (c == "\n") begin
               cline_in = (cline_ff < LINE_MAX) ? cline_ff + LINE_BITS'(1) : LINE_MAX;
               ccol_in  = '0;
            end else begin
               ccol_in = (ccol_ff < LEN_MAX) ? ccol_ff + LEN_BITS'(1) : LEN_MAX;
            end
         end
         if (n == 2'd1) r[0].last = 1'b1;
         if (n == 2'd2) r[1].last = 1'b1;
      end
   end

   // queue: drop head on pop, append new tokens behind
   always_comb begin
      logic [1:0] base;
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      base = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         base = cnt_ff - 2'd1;
      end
      if (n != 2'd0) begin
         q_in[base[0]] = r[0];
         if (n == 2'd2) q_in[1] = r[1];
      end
      cnt_in = base + n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         cnt_ff    <= '0;
         mode_ff   <= M_IDLE;
         head_ff   <= '0;
         word_ff   <= '0;
         len_ff    <= '0;
         tline_ff  <= '0;
         tcol_ff   <= '0;
         cline_ff  <= '0;
         ccol_ff   <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         cnt_ff    <= cnt_in;
         mode_ff   <= mode_in;
         head_ff   <= head_in;
         word_ff   <= word_in;
         len_ff    <= len_in;
         tline_ff  <= tline_in;
         tcol_ff   <= tcol_in;
         cline_ff  <= cline_in;
         ccol_ff   <= ccol_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

endmodule

[tb/tb_c_like_token_lexer_core.sv]
// Testbench for the C-like token lexer core: directed table plus random source text.
`timescale 1ns / 1ps

module tb_c_like_token_lexer_core;
   import clex_pkg::*;

   localparam int LEN_MAX  = 4095;
   localparam int LINE_MAX = 65535;
   localparam int WATCHDOG = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   c_like_token_lexer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Lexer shadow state, kept in step with every accepted transfer.
   lex_mode_type sh_mode;
   logic [23:0]  sh_head;
   logic [63:0]  sh_word;
   int           sh_len, sh_tline, sh_tcol, sh_line, sh_col;

   rsp_type token_queue[$];
   int      mismatches;
   int      idle_cycles;
   bit      timed_out;

   // Typed-in expectations, one entry per directed transfer, in order.
   bit      typed_has_q[$];
   rsp_type typed_q[$];

   // Directed rows: byte stream with an optional typed-in token.
   typedef struct {
      logic    op;
      logic [7:0] ch;
      bit      has_tok;
      rsp_type tok;
   } row_type;
   row_type rows[$];

   function automatic rsp_type mk(int kind, int ln, int col, int len);
      rsp_type t;
      t.kind = 7'(kind); t.start_line = 16'(ln); t.start_col = 12'(col);
      t.length = 12'(len); t.last = 1'b0;
      return t;
   endfunction

   function automatic bit space_ch(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B
         || c == 8'h0C || c == 8'h0D;
   endfunction

   function automatic bit digit_ch(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit word_ch(logic [7:0] c);
      return c == 8'h5F || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic bit oper_ch(logic [7:0] c);
      case (c)
         "+", "-", "*", "/", "%", "=", ".", "&", "|", "^", "!", "~", "(", "[",
         "<", ">", "?", ":": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic int punct_slot(logic [7:0] c);
      case (c)
         "{": return 0;
         "}": return 1;
         ";": return 2;
         ",": return 3;
         "]": return 4;
         ")": return 5;
         default: return -1;
      endcase
   endfunction

   // Keyword spellings, right aligned, in code order.
   function automatic int word_kind();
      string kw[33] = '{"if", "do", "int", "for", "auto", "case", "char", "else",
         "enum", "goto", "long", "void", "break", "const", "float", "short",
         "union", "while", "double", "extern", "return", "signed", "sizeof",
         "static", "struct", "switch", "default", "typedef", "continue",
         "register", "restrict", "unsigned", "volatile"};
      logic [63:0] packed_w;
      if (sh_len > 8) return K_IDENT;
      for (int i = 0; i < 33; i++) begin
         packed_w = 64'd0;
         for (int k = 0; k < kw[i].len(); k++) packed_w = {packed_w[55:0], kw[i][k]};
         if (kw[i].len() == sh_len && packed_w == sh_word) return i;
      end
      return K_IDENT;
   endfunction

   function automatic int oper_kind_of();
      logic [7:0] c1, c2, c3;
      int b;
      b  = K_OP_BASE;
      c1 = sh_head[7:0];
      c2 = sh_len >= 2 ? sh_head[15:8] : 8'd0;
      c3 = sh_len >= 3 ? sh_head[23:16] : 8'd0;
      case (c1)
         "+": return b + (c2 == "+" ? 1 : c2 == "=" ? 2 : 0);
         "-": return b + (c2 == "-" ? 4 : c2 == "=" ? 5 : c2 == ">" ? 6 : 3);
         "*": return b + (c2 == "=" ? 8 : 7);
         "/": return b + (c2 == "=" ? 10 : 9);
         "%": return b + (c2 == "=" ? 12 : 11);
         "=": return b + (c2 == "=" ? 14 : 13);
         "&": return b + (c2 == "=" ? 16 : c2 == "&" ? 17 : 15);
         "|": return b + (c2 == "=" ? 19 : c2 == "|" ? 20 : 18);
         "^": return b + (c2 == "=" ? 22 : 21);
         "!": return b + (c2 == "=" ? 24 : 23);
         "(": return b + 25;
         ".": return b + 26;
         "[": return b + 27;
         "~": return b + (c2 == "=" ? 29 : 28);
         "<": return b + (c2 == "=" ? 31 : c2 == "<" ? (c3 == "=" ? 33 : 32) : 30);
         ">": return b + (c2 == "=" ? 35 : c2 == ">" ? (c3 == "=" ? 37 : 36) : 34);
         ":": return b + 38;
         default: return b + 39;
      endcase
   endfunction

   function automatic void clear_shadow();
      sh_mode = M_IDLE; sh_head = '0; sh_word = '0;
      sh_len = 0; sh_tline = 0; sh_tcol = 0; sh_line = 0; sh_col = 0;
   endfunction

   function automatic void close_token(ref rsp_type toks[$], input int kind);
      toks.push_back(mk(kind, sh_tline, sh_tcol, sh_len));
      sh_mode = M_IDLE;
   endfunction

   function automatic void open_token(lex_mode_type m, logic [7:0] c, int pl, int pc);
      sh_mode = m; sh_tline = pl; sh_tcol = pc; sh_len = 1;
      sh_head = {16'd0, c}; sh_word = {56'd0, c};
   endfunction

   function automatic void grow();
      if (sh_len < LEN_MAX) sh_len++;
   endfunction

   function automatic void grow_oper(logic [7:0] c);
      if (sh_len < 3) sh_head[8*sh_len +: 8] = c;
      grow();
   endfunction

   function automatic void lex_idle(ref rsp_type toks[$], input logic [7:0] c,
                                    input int pl, input int pc);
      int p;
      p = punct_slot(c);
      if (space_ch(c)) return;
      if (c == "#") open_token(M_DIRECTIVE, c, pl, pc);
      else if (c == "/") open_token(M_SLASH, c, pl, pc);
      else if (word_ch(c)) open_token(M_IDENT, c, pl, pc);
      else if (digit_ch(c)) open_token(M_NUMBER, c, pl, pc);
      else if (c == 8'h22) open_token(M_STRING, c, pl, pc);
      else if (oper_ch(c)) open_token(M_OPER, c, pl, pc);
      else if (p >= 0) toks.push_back(mk(K_PUN_BASE + p, pl, pc, 1));
      else toks.push_back(mk(K_ERROR, pl, pc, 1));
   endfunction

   // Advance the shadow lexer by one item and return the tokens it yields.
   function automatic void lex_item(req_type it, ref rsp_type toks[$]);
      logic [7:0] c;
      int pl, pc;
      c = it.ch; pl = sh_line; pc = sh_col;
      toks.delete();
      if (it.op == OP_EOI) begin
         case (sh_mode)
            M_DIRECTIVE: close_token(toks, K_DIRECTIVE);
            M_SLASH, M_OPER: close_token(toks, oper_kind_of());
            M_LINE: close_token(toks, K_LINE_CMT);
            M_BLOCK, M_BLOCK_STAR: close_token(toks, K_BLOCK_CMT);
            M_IDENT: close_token(toks, word_kind());
            M_NUMBER: close_token(toks, K_NUM);
            M_STRING: close_token(toks, K_STR);
            default: ;
         endcase
         toks.push_back(mk(K_END, pl, pc, 1));
         toks[toks.size()-1].last = 1'b1;
         clear_shadow();
         return;
      end
      case (sh_mode)
         M_DIRECTIVE: begin
            grow();
            if (c == 8'h0A) close_token(toks, K_DIRECTIVE);
         end
         M_SLASH: begin
            if (c == "/") begin sh_mode = M_LINE; grow(); end
            else if (c == "*") begin sh_mode = M_BLOCK; grow(); end
            else if (oper_ch(c)) begin sh_mode = M_OPER; grow_oper(c); end
            else begin close_token(toks, oper_kind_of()); lex_idle(toks, c, pl, pc); end
         end
         M_LINE: begin
            if (c == 8'h0A) close_token(toks, K_LINE_CMT);
            else grow();
         end
         M_BLOCK: begin
            grow();
            if (c == "*") sh_mode = M_BLOCK_STAR;
         end
         M_BLOCK_STAR: begin
            grow();
            if (c == "/") close_token(toks, K_BLOCK_CMT);
            else if (c != "*") sh_mode = M_BLOCK;
         end
         M_IDENT: begin
            if (word_ch(c) || digit_ch(c)) begin
               grow();
               sh_word = {sh_word[55:0], c};
            end else begin
               close_token(toks, word_kind());
               lex_idle(toks, c, pl, pc);
            end
         end
         M_NUMBER: begin
            if (digit_ch(c) || c == ".") grow();
            else begin close_token(toks, K_NUM); lex_idle(toks, c, pl, pc); end
         end
         M_STRING: begin
            grow();
            if (c == 8'h22) close_token(toks, K_STR);
         end
         M_OPER: begin
            if (oper_ch(c)) grow_oper(c);
            else begin close_token(toks, oper_kind_of()); lex_idle(toks, c, pl, pc); end
         end
         default: begin
            sh_mode = M_IDLE;
            lex_idle(toks, c, pl, pc);
         end
      endcase
      if (c == 8'h0A) begin
         if (sh_line < LINE_MAX) sh_line++;
         sh_col = 0;
      end else if (sh_col < LEN_MAX) sh_col++;
      if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Text pool for the random part: fragments of source, mostly well-formed.
   string frags[] = '{"if", "do", "int", "for", "auto", "case", "char", "else",
      "enum", "goto", "long", "void", "break", "const", "float", "short", "union",
      "while", "double", "extern", "return", "signed", "sizeof", "static",
      "struct", "switch", "default", "typedef", "continue", "register",
      "restrict", "unsigned", "volatile", "whilex", "volatiles", "vol", "_x9",
      "Abc_12", "x", "+", "++", "+=", "-", "--", "-=", "->", "*", "*=", "/", "/=",
      "%", "%=", "=", "==", "&", "&=", "&&", "|", "|=", "||", "^", "^=", "!",
      "!=", "(", ".", "[", "~", "~=", "<", "<=", "<<", "<<=", ">", ">=", ">>",
      ">>=", ":", "?", "{", "}", ";", ",", "]", ")", "0", "123", "3.14", "1..2",
      "\"str\"", "\"a b\"", "// note\n", "/* c */", "/**/", "/* ** */",
      "#define X 1\n", " ", "  ", "\n", "\t", "\r\n", "/-", "+/*", "<<=="};

   // Drive one item and track the accepted transfer; valid drops only for a gap.
   task automatic send_item(req_type it);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
   endtask

   // Prediction at acceptance; a typed-in token replaces it for its row.
   always @(posedge clock) begin
      rsp_type toks[$];
      bit      typed;
      rsp_type typed_tok;
      if (!reset && req_valid && !req_stall) begin
         lex_item(req_data, toks);
         if (typed_has_q.size() > 0) begin
            typed     = typed_has_q.pop_front();
            typed_tok = typed_q.pop_front();
            if (typed) begin
               toks.delete();
               toks.push_back(typed_tok);
            end
         end
         foreach (toks[i]) token_queue.push_back(toks[i]);
      end
   end

   // Compare every token at its transfer with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token kind=%0d line=%0d col=%0d len=%0d",
                        rsp_data.kind, rsp_data.start_line, rsp_data.start_col,
                        rsp_data.length);
         end else begin
            want = token_queue.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("token mismatch: exp k=%0d l=%0d c=%0d n=%0d last=%0d",
                           want.kind, want.start_line, want.start_col, want.length,
                           want.last, "  got k=%0d l=%0d c=%0d n=%0d last=%0d",
                           rsp_data.kind, rsp_data.start_line, rsp_data.start_col,
                           rsp_data.length, rsp_data.last);
            end
         end
      end
   end

   // Receiver stall: random, with runs of no stall at all.
   int stall_left;
   int calm_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         calm_left = 0;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 200);
         else stall_left = gap_len();
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: count cycles with no transfer on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         timed_out = 1'b1;
         $display("c_like_token_lexer_core regression: fail");
         $finish;
      end
   end

   task automatic add_row(logic op, logic [7:0] c);
      row_type r;
      r.op = op; r.ch = c; r.has_tok = 1'b0;
      rows.push_back(r);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_row(OP_CHAR, s[i]);
   endtask

   task automatic add_checked(logic op, logic [7:0] c, rsp_type t);
      row_type r;
      r.op = op; r.ch = c; r.has_tok = 1'b1; r.tok = t;
      rows.push_back(r);
   endtask

   initial begin
      rsp_type tok;
      req_type it;
      int sent;
      string s;
      mismatches = 0;
      timed_out = 1'b0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      clear_shadow();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table: tokens typed in where plain from the field rules.
      tok = mk(K_ERROR, 0, 0, 1); tok.last = 1'b1;
      add_checked(OP_CHAR, 8'h00, tok);                  // NUL at reset position
      tok = mk(K_ERROR, 0, 1, 1); tok.last = 1'b1;
      add_checked(OP_CHAR, 8'hFF, tok);                  // high byte
      tok = mk(K_PUN_BASE, 0, 2, 1); tok.last = 1'b1;
      add_checked(OP_CHAR, "{", tok);
      add_text("\t\v\f\r \n");                           // all whitespace
      add_text("while volatile");
      add_text(" <<= x/=/");
      add_text("/ c\n");
      add_text("/*/ */");
      add_text("1.2a\"s\"#x\n");
      add_text("(+");
      add_row(OP_EOI, 8'hA5);                            // open operator, then end
      add_text("\"abc");
      add_row(OP_EOI, 8'h5A);                            // unterminated string
      tok = mk(K_END, 0, 0, 1); tok.last = 1'b1;
      add_checked(OP_EOI, 8'h00, tok);                   // end right after end

      foreach (rows[i]) begin
         it.op = rows[i].op; it.ch = rows[i].ch;
         typed_has_q.push_back(rows[i].has_tok);
         typed_q.push_back(rows[i].tok);
         send_item(it);
      end

      // Random part: source fragments, noise bytes and stray ends.
      sent = 0;
      while (sent < 1850) begin
         if ($urandom_range(0, 99) < 85) begin
            s = frags[$urandom_range(0, frags.size() - 1)];
            for (int k = 0; k < s.len(); k++) begin
               it.op = OP_CHAR; it.ch = s[k];
               send_item(it); sent++;
            end
         end else if ($urandom_range(0, 9) < 8) begin
            it.op = OP_CHAR; it.ch = 8'($urandom_range(0, 255));
            send_item(it); sent++;
         end else begin
            it.op = OP_EOI; it.ch = 8'($urandom_range(0, 255));
            send_item(it); sent++;
         end
      end
      it.op = OP_EOI; send_item(it);
      req_valid <= 1'b0;

      // Drain, then a short settle.
      while (token_queue.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && !rsp_valid)
         $display("c_like_token_lexer_core regression: pass");
      else
         $display("c_like_token_lexer_core regression: fail");
      $finish;
   end

endmodule
